// ===== sv/rsa_pkg.sv =====
// Shared types, constants and helpers for the register slot allocator.
package rsa_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int FIXED_REGS_DEF  = 10;

  localparam int OWNER_W = 17;
  localparam int SLOT_W  = 11;
  localparam int INDEX_W = 6;
  localparam int LOCAL_W = 10;

  localparam logic [15:0]        RESERVED_MASK = 16'h030D;
  localparam logic [OWNER_W-1:0] NO_OWNER      = '1;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_FIND    = 2'd2,
    KIND_GET     = 2'd3
  } kind_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  localparam logic CFG_STATIC = 1'b0;
  localparam logic CFG_LOCALS = 1'b1;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic               busy;
    logic               stack;
    logic [SLOT_W-1:0]  slot;
  } entry_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [INDEX_W-1:0] index;
    logic [OWNER_W-1:0] owner;
    logic               busy;
    logic               stack;
    logic [SLOT_W-1:0]  slot;
  } res_t;

  function automatic entry_t fixed_entry(input logic [3:0] i);
    entry_t e;
    e.owner = NO_OWNER;
    e.busy  = RESERVED_MASK[i];
    e.stack = 1'b0;
    e.slot  = SLOT_W'(i);
    return e;
  endfunction

endpackage

// ===== sv/rsa_table.sv =====
// Entry table memory with registered read and reset view of fixed entries.
module rsa_table import rsa_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int FIXED = FIXED_REGS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output entry_t                   rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  entry_t                   wr_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int FW = (FIXED > 1) ? $clog2(FIXED) : 1;

  entry_t mem [DEPTH];
  entry_t mem_q;
  logic [FIXED-1:0] written;
  logic fix_q;
  logic [3:0] fix_idx_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q     <= mem[rd_addr];
    fix_idx_q <= 4'(rd_addr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      fix_q   <= 1'b0;
    end else begin
      fix_q <= (rd_addr < IW'(FIXED)) && !written[rd_addr[FW-1:0]];
      if (wr_en && (wr_addr < IW'(FIXED))) begin
        written[wr_addr[FW-1:0]] <= 1'b1;
      end
    end
  end

  assign rd_data = fix_q ? fixed_entry(fix_idx_q) : mem_q;

endmodule

// ===== sv/rsa_seq.sv =====
// Sequencer: scans, fetches and updates table entries one at a time.
module rsa_seq import rsa_pkg::*; #(
  parameter int DEPTH = TABLE_DEPTH_DEF,
  parameter int FIXED = FIXED_REGS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               kind,
  input  logic [OWNER_W-1:0]       owner_id,
  input  logic [INDEX_W-1:0]       entry_index,
  input  logic                     is_static_method,
  input  logic [LOCAL_W-1:0]       local_count,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  input  entry_t                   rd_data,
  output logic                     wr_en,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output entry_t                   wr_data,
  output logic                     res_valid,
  input  logic                     res_ready,
  output res_t                     res
);

  localparam int IW   = $clog2(DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_FETCH = 5'b00100,
    S_APPLY = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state, state_next;
  logic [1:0] op, op_next;
  logic [OWNER_W-1:0] key, key_next;
  logic [CW-1:0] ptr, ptr_next;
  logic [CW-1:0] count, count_next;
  logic pend, pend_next;
  logic [IW-1:0] pend_idx, pend_idx_next;
  res_t res_next;
  logic hit;
  logic [SLOT_W-1:0] slot_new;

  function automatic res_t mk_res(input logic [IW-1:0] i, input entry_t e);
    res_t r;
    r.status = STATUS_OK;
    r.index  = INDEX_W'(i);
    r.owner  = e.owner;
    r.busy   = e.busy;
    r.stack  = e.stack;
    r.slot   = e.slot;
    return r;
  endfunction

  function automatic res_t mk_err(input logic [1:0] s);
    res_t r;
    r        = '0;
    r.status = s;
    return r;
  endfunction

  assign slot_new = SLOT_W'({{(LOCAL_W - 1){1'b0}}, ~is_static_method})
                  + SLOT_W'(local_count)
                  + SLOT_W'(count - CW'(FIXED));

  assign hit = pend && ((op == KIND_ALLOC) ? !rd_data.busy : (rd_data.owner == key));

  always_comb begin
    state_next    = state;
    op_next       = op;
    key_next      = key;
    ptr_next      = ptr;
    count_next    = count;
    pend_next     = 1'b0;
    pend_idx_next = ptr[IW-1:0];
    res_next      = res;
    rd_addr       = ptr[IW-1:0];
    wr_en         = 1'b0;
    wr_addr       = pend_idx;
    wr_data       = rd_data;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next  = kind;
          key_next = owner_id;
          if ((kind == KIND_ALLOC) || (kind == KIND_FIND)) begin
            ptr_next   = '0;
            state_next = S_SCAN;
          end else if (CMPW'(entry_index) >= CMPW'(count)) begin
            res_next   = mk_err(STATUS_MISS);
            state_next = S_DONE;
          end else begin
            ptr_next   = CW'(entry_index);
            state_next = S_FETCH;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (op == KIND_ALLOC) begin
            wr_en         = 1'b1;
            wr_data.owner = key;
            wr_data.busy  = 1'b1;
            res_next      = mk_res(pend_idx, wr_data);
          end else begin
            res_next = mk_res(pend_idx, rd_data);
          end
          state_next = S_DONE;
        end else if (ptr < count) begin
          pend_next = 1'b1;
          ptr_next  = ptr + 1'b1;
        end else if (!pend) begin
          if (op != KIND_ALLOC) begin
            res_next = mk_err(STATUS_MISS);
          end else if (count == CW'(DEPTH)) begin
            res_next = mk_err(STATUS_FULL);
          end else begin
            wr_en         = 1'b1;
            wr_addr       = count[IW-1:0];
            wr_data.owner = key;
            wr_data.busy  = 1'b1;
            wr_data.stack = 1'b1;
            wr_data.slot  = slot_new;
            count_next    = count + 1'b1;
            res_next      = mk_res(count[IW-1:0], wr_data);
          end
          state_next = S_DONE;
        end
      end
      S_FETCH: begin
        pend_next  = 1'b1;
        state_next = S_APPLY;
      end
      S_APPLY: begin
        if (op == KIND_RELEASE) begin
          wr_en         = 1'b1;
          wr_data.owner = NO_OWNER;
          wr_data.busy  = 1'b0;
          res_next      = mk_res(pend_idx, wr_data);
        end else begin
          res_next = mk_res(pend_idx, rd_data);
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CW'(FIXED);
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    key      <= key_next;
    ptr      <= ptr_next;
    pend_idx <= pend_idx_next;
    res      <= res_next;
  end

  assign in_ready  = (state == S_IDLE) && !rst;
  assign res_valid = (state == S_DONE);

endmodule

// ===== sv/register_slot_allocator.sv =====
// Register slot allocator top level: config registers, table, sequencer, output word.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_ready    kind, owner_id, entry_index
//   out      output     out_valid / out_ready  status_code .. result_slot
//   cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Allocate and find scan the table one entry per cycle through a single read port,
// over the entries in use. Release and get fetch the indexed entry, then free or
// report it; a bad index goes straight to a miss. Reset returns the table to its
// fixed entries at once. A result word waits in the output register; in_ready drops
// while an item is in work or a finished word cannot enter a full output register.
module register_slot_allocator import rsa_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FIXED_REGS  = FIXED_REGS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [OWNER_W-1:0] owner_id,
  input  logic [INDEX_W-1:0] entry_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status_code,
  output logic [INDEX_W-1:0] result_index,
  output logic [OWNER_W-1:0] result_owner,
  output logic               result_busy,
  output logic               result_is_stack,
  output logic [SLOT_W-1:0]  result_slot,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [LOCAL_W-1:0] cfg_data
);

  localparam int IW = $clog2(TABLE_DEPTH);

  logic is_static_method;
  logic [LOCAL_W-1:0] local_count;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  entry_t rd_data;
  entry_t wr_data;
  logic wr_en;
  logic res_valid;
  logic res_ready;
  res_t res;
  res_t out_word;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      is_static_method <= 1'b0;
      local_count      <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_STATIC) begin
        is_static_method <= cfg_data[0];
      end else begin
        local_count <= cfg_data;
      end
    end
  end

  rsa_table #(
    .DEPTH (TABLE_DEPTH),
    .FIXED (FIXED_REGS)
  ) u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  rsa_seq #(
    .DEPTH (TABLE_DEPTH),
    .FIXED (FIXED_REGS)
  ) u_seq (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .owner_id         (owner_id),
    .entry_index      (entry_index),
    .is_static_method (is_static_method),
    .local_count      (local_count),
    .rd_addr          (rd_addr),
    .rd_data          (rd_data),
    .wr_en            (wr_en),
    .wr_addr          (wr_addr),
    .wr_data          (wr_data),
    .res_valid        (res_valid),
    .res_ready        (res_ready),
    .res              (res)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_word <= res;
    end
  end

  assign status_code     = out_word.status;
  assign result_index    = out_word.index;
  assign result_owner    = out_word.owner;
  assign result_busy     = out_word.busy;
  assign result_is_stack = out_word.stack;
  assign result_slot     = out_word.slot;

endmodule
